// ===== sv/lcs_pkg.sv =====
package lcs_pkg;

  localparam int MAX_PIXELS = 4096;
  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int PIX_W = 8;
  localparam int DIV_STEPS = PIX_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_in;
    logic             first;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last;
    logic             flat_frame;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MAP
  } state_t;

  typedef struct packed {
    logic load_en;
    logic rd_en;
    logic div_start;
    logic div_run;
    logic map_en;
  } cmd_t;

  typedef struct packed {
    logic rd_hit;
    logic gain_valid;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/lcs_ctrl.sv =====
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_op,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.load_en = 1'b1;
          end else if (stat.rd_hit) begin
            cmd.rd_en = 1'b1;
            if (stat.gain_valid) begin
              state_next = S_MAP;
            end else begin
              cmd.div_start = 1'b1;
              state_next = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_done) begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        if (stat.out_free) begin
          cmd.map_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lcs_dp.sv =====
module lcs_dp
  import lcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_word_t  in_word,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [PIX_W-1:0]  mem [MAX_PIXELS];
  logic [PIX_W-1:0]  rd_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  read_index;
  logic [PIX_W-1:0]  fmin;
  logic [PIX_W-1:0]  fmax;
  logic              gain_valid;
  logic [PIX_W-1:0]  quo;
  logic [PIX_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic [CNT_W-1:0]  count_base;
  logic [PIX_W-1:0]  fmin_base;
  logic [PIX_W-1:0]  fmax_base;
  logic              wr_ok;
  logic [PIX_W-1:0]  span;
  logic [PIX_W:0]    rem_shift;
  logic [PIX_W:0]    rem_sub;
  logic              rem_ge;
  logic              flat;
  logic [PIX_W-1:0]  diff;
  logic [2*PIX_W-1:0] prod;
  logic [PIX_W-1:0]  mapped;

  // A load that starts a frame sees an empty frame before it is stored.
  always_comb begin
    count_base = in_word.first ? '0 : count;
    fmin_base = in_word.first ? PIX_MAX : fmin;
    fmax_base = in_word.first ? '0 : fmax;
    wr_ok = count_base < CNT_W'(MAX_PIXELS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && wr_ok) begin
      mem[count_base[ADDR_W-1:0]] <= in_word.pixel_in;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[read_index[ADDR_W-1:0]];
    end
  end

  // Restoring divider for the gain 255 / (max - min), one quotient bit per cycle.
  always_comb begin
    span = fmax - fmin;
    rem_shift = {rem, quo[PIX_W-1]};
    rem_sub = rem_shift - {1'b0, span};
    rem_ge = rem_shift >= {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= PIX_MAX;
      rem <= '0;
    end else if (cmd.div_run) begin
      quo <= {quo[PIX_W-2:0], rem_ge};
      rem <= rem_ge ? rem_sub[PIX_W-1:0] : rem_shift[PIX_W-1:0];
    end
  end

  always_comb begin
    flat = fmax <= fmin;
    diff = rd_data - fmin;
    prod = diff * quo;
    if (flat || (rd_data < fmin)) begin
      mapped = '0;
    end else if (prod > {{PIX_W{1'b0}}, PIX_MAX}) begin
      mapped = PIX_MAX;
    end else begin
      mapped = prod[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      read_index <= '0;
      fmin <= PIX_MAX;
      fmax <= '0;
      gain_valid <= 1'b0;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        gain_valid <= 1'b0;
        if (in_word.first) begin
          read_index <= '0;
        end
        if (wr_ok) begin
          count <= count_base + CNT_W'(1);
          fmin <= (in_word.pixel_in < fmin_base) ? in_word.pixel_in : fmin_base;
          fmax <= (in_word.pixel_in > fmax_base) ? in_word.pixel_in : fmax_base;
        end
      end
      if (cmd.div_start) begin
        step <= '0;
      end else if (cmd.div_run) begin
        step <= step + STEP_W'(1);
        if (stat.div_done) begin
          gain_valid <= 1'b1;
        end
      end
      if (cmd.map_en) begin
        read_index <= read_index + CNT_W'(1);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      out_word.pixel_out <= mapped;
      out_word.last <= (read_index + CNT_W'(1)) == count;
      out_word.flat_frame <= flat;
    end
  end

  always_comb begin
    stat.rd_hit = read_index < count;
    stat.gain_valid = gain_valid;
    stat.div_done = step == STEP_W'(DIV_STEPS - 1);
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

// ===== sv/linear_contrast_stretch.sv =====
// Channel  Direction  Word        Handshake
// in       input      in_word_t   in_valid / in_stall
// out      output     out_word_t  out_valid / out_stall
//
// A load is taken whenever the block is idle. A read goes straight to mapping when the gain is
// current; after any load, the 8-step divider first recomputes it.
// A read past the end of the frame is taken and gives no word.
// Reset clears counts and the gain valid flag and sets minimum to 255 and maximum to 0; the pixel store is not cleared.
// Loads are taken while a result waits on a stalled output; a read is taken and then
// holds the input until the output register frees.
module linear_contrast_stretch
  import lcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t  cmd;
  stat_t stat;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_word),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
